// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros shared by the list engine RTL
// Clocked concurrent checks with an active-low reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset
`define AM_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent holds in the cycle after the antecedent
`define AM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/ile_pkg.sv -----
// ----------------------------------------------------------------------------
// ile_pkg
// Types and fixed field widths for the indexed list engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ile_pkg;

	// Fixed word field widths
	localparam int OP_W     = 3;
	localparam int POS_W    = 6;
	localparam int VAL_W    = 32;
	localparam int DATA_W   = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 7;

	// Operation codes (six and seven are ignored)
	typedef enum logic [OP_W-1:0] {
		OP_APPEND  = 3'd0,
		OP_INSERT  = 3'd1,
		OP_REPLACE = 3'd2,
		OP_POP     = 3'd3,
		OP_DELETE  = 3'd4,
		OP_GET     = 3'd5
	} op_t;

	// Result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	// Sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_START,
		S_RD,
		S_SHIFT,
		S_FIN,
		S_DONE
	} state_t;

	// One result word
	typedef struct packed {
		logic [DATA_W-1:0]  data_out;
		status_t            status;
		logic [COUNT_W-1:0] count;
		logic               is_empty;
	} result_t;

endpackage

`default_nettype wire

// ----- src/ile_req_if.sv -----
// ----------------------------------------------------------------------------
// ile_req_if
// Request channel: operation, position and value with valid/ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ile_req_if;
	logic                      valid;
	logic                      ready;
	logic [ile_pkg::OP_W-1:0]  operation;
	logic [ile_pkg::POS_W-1:0] position;
	logic [ile_pkg::VAL_W-1:0] value;

	modport source (output valid, output operation, output position, output value,
		input ready);
	modport sink (input valid, input operation, input position, input value,
		output ready);
endinterface

`default_nettype wire

// ----- src/ile_rsp_if.sv -----
// ----------------------------------------------------------------------------
// ile_rsp_if
// Response channel: data, status, count and empty flag with valid/ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ile_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [ile_pkg::DATA_W-1:0]   data_out;
	logic [ile_pkg::STATUS_W-1:0] status;
	logic [ile_pkg::COUNT_W-1:0]  count;
	logic                         is_empty;

	modport source (output valid, output data_out, output status, output count,
		output is_empty, input ready);
	modport sink (input valid, input data_out, input status, input count,
		input is_empty, output ready);
endinterface

`default_nettype wire

// ----- src/ile_mem.sv -----
// ----------------------------------------------------------------------------
// ile_mem
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ile_mem #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port, registered read data
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ----- src/ile_step.sv -----
// ----------------------------------------------------------------------------
// ile_step
// Shared address step unit: increments or decrements an entry index.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ile_step #(
	parameter int W = 6
) (
	input  logic [W-1:0] a,
	input  logic         up,
	output logic [W-1:0] y
);

	// Wraps modulo 2**W
	always_comb begin
		if (up) begin
			y = a + W'(1);
		end else begin
			y = a - W'(1);
		end
	end

endmodule

`default_nettype wire

// ----- src/ile_seq.sv -----
// ----------------------------------------------------------------------------
// ile_seq
// Request sequencer: checks the request, walks the entry store one entry per
// cycle for insert and delete, and keeps the entry count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ile_seq #(
	parameter int CAPACITY  = 64,
	parameter int WORD_BITS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// request word
	input  logic                        req_valid,
	output logic                        req_ready,
	input  logic [ile_pkg::OP_W-1:0]    operation,
	input  logic [ile_pkg::POS_W-1:0]   position,
	input  logic [ile_pkg::VAL_W-1:0]   value,
	// finished result
	output logic                        res_valid,
	output ile_pkg::result_t            res,
	input  logic                        res_take,
	// entry store
	output logic                        mem_we,
	output logic [$clog2(CAPACITY)-1:0] mem_waddr,
	output logic [WORD_BITS-1:0]        mem_wdata,
	output logic [$clog2(CAPACITY)-1:0] mem_raddr,
	input  logic [WORD_BITS-1:0]        mem_rdata
);

	localparam int IW   = $clog2(CAPACITY);
	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int CMPW = (CW > ile_pkg::POS_W) ? CW : ile_pkg::POS_W;
	localparam int DW   = ile_pkg::DATA_W;
	localparam int NW   = ile_pkg::COUNT_W;

	ile_pkg::state_t  state_q, state_d;
	ile_pkg::op_t     op_q, op_d;
	ile_pkg::op_t     req_op;
	ile_pkg::status_t status_q, status_d, req_status;
	logic [IW-1:0]        pos_q, pos_d;
	logic [IW-1:0]        src_q, src_d;
	logic [IW-1:0]        dst_q, dst_d;
	logic [WORD_BITS-1:0] word_q, word_d;
	logic [WORD_BITS-1:0] data_q, data_d;
	logic [CW-1:0]        fill_q, fill_d;

	logic          in_range;
	logic          is_full;
	logic          req_known;
	logic [IW-1:0] fill_idx;
	logic [IW-1:0] step_a;
	logic          step_up;
	logic [IW-1:0] step_y;
	logic [IW-1:0] last_a;
	logic          at_last;

	// Request checks against the current count
	assign req_op   = ile_pkg::op_t'(operation);
	assign in_range = CMPW'(position) < CMPW'(fill_q);
	assign is_full  = fill_q == CW'(CAPACITY);
	assign fill_idx = IW'(fill_q);

	always_comb begin
		req_status = ile_pkg::ST_OK;
		req_known  = 1'b1;
		unique case (req_op)
			ile_pkg::OP_APPEND: begin
				if (is_full) req_status = ile_pkg::ST_FULL;
			end
			ile_pkg::OP_INSERT: begin
				if (!in_range)    req_status = ile_pkg::ST_RANGE;
				else if (is_full) req_status = ile_pkg::ST_FULL;
			end
			ile_pkg::OP_REPLACE, ile_pkg::OP_DELETE, ile_pkg::OP_GET: begin
				if (!in_range) req_status = ile_pkg::ST_RANGE;
			end
			ile_pkg::OP_POP: begin
				if (fill_q == '0) req_status = ile_pkg::ST_EMPTY;
			end
			default: begin
				req_known = 1'b0;
			end
		endcase
	end

	// Shared index stepper
	ile_step #(.W(IW)) u_step (
		.a  (step_a),
		.up (step_up),
		.y  (step_y)
	);

	// Index equals count minus one (last held entry)
	assign at_last = (CW'(last_a) + CW'(1)) == fill_q;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ile_pkg::S_IDLE;
			fill_q  <= '0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		op_q     <= op_d;
		status_q <= status_d;
		pos_q    <= pos_d;
		src_q    <= src_d;
		dst_q    <= dst_d;
		word_q   <= word_d;
		data_q   <= data_d;
	end

	// Next state and outputs
	always_comb begin
		state_d   = state_q;
		op_d      = op_q;
		status_d  = status_q;
		pos_d     = pos_q;
		src_d     = src_q;
		dst_d     = dst_q;
		word_d    = word_q;
		data_d    = data_q;
		fill_d    = fill_q;
		req_ready = 1'b0;
		res_valid = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = pos_q;
		mem_wdata = word_q;
		mem_raddr = pos_q;
		step_a    = src_q;
		step_up   = 1'b0;
		last_a    = src_q;

		unique case (state_q)
			ile_pkg::S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					op_d     = req_op;
					status_d = req_status;
					pos_d    = IW'(position);
					word_d   = WORD_BITS'(value);
					data_d   = '0;
					if (req_known && req_status == ile_pkg::ST_OK) begin
						state_d = ile_pkg::S_START;
					end else begin
						state_d = ile_pkg::S_DONE;
					end
				end
			end

			ile_pkg::S_START: begin
				state_d = ile_pkg::S_DONE;
				unique case (op_q)
					ile_pkg::OP_APPEND: begin
						mem_we    = 1'b1;
						mem_waddr = fill_idx;
						fill_d    = fill_q + CW'(1);
					end
					ile_pkg::OP_INSERT: begin
						// read the last entry, it moves to index count
						step_a    = fill_idx;
						mem_raddr = step_y;
						src_d     = step_y;
						dst_d     = fill_idx;
						state_d   = ile_pkg::S_SHIFT;
					end
					ile_pkg::OP_POP: begin
						step_a    = fill_idx;
						mem_raddr = step_y;
						state_d   = ile_pkg::S_RD;
					end
					ile_pkg::OP_REPLACE, ile_pkg::OP_DELETE, ile_pkg::OP_GET: begin
						state_d = ile_pkg::S_RD;
					end
					default: begin
						state_d = ile_pkg::S_DONE;
					end
				endcase
			end

			ile_pkg::S_RD: begin
				data_d  = mem_rdata;
				state_d = ile_pkg::S_DONE;
				last_a  = pos_q;
				unique case (op_q)
					ile_pkg::OP_REPLACE: begin
						mem_we = 1'b1;
					end
					ile_pkg::OP_POP: begin
						fill_d = fill_q - CW'(1);
					end
					ile_pkg::OP_DELETE: begin
						if (at_last) begin
							fill_d = fill_q - CW'(1);
						end else begin
							// close the gap: entry pos+1 moves to pos first
							step_a    = pos_q;
							step_up   = 1'b1;
							mem_raddr = step_y;
							src_d     = step_y;
							dst_d     = pos_q;
							state_d   = ile_pkg::S_SHIFT;
						end
					end
					default: begin
						state_d = ile_pkg::S_DONE;
					end
				endcase
			end

			ile_pkg::S_SHIFT: begin
				// move the entry read last cycle, fetch the next one
				mem_we    = 1'b1;
				mem_waddr = dst_q;
				mem_wdata = mem_rdata;
				dst_d     = src_q;
				step_a    = src_q;
				step_up   = op_q != ile_pkg::OP_INSERT;
				mem_raddr = step_y;
				if (op_q == ile_pkg::OP_INSERT) begin
					if (src_q == pos_q) begin
						state_d = ile_pkg::S_FIN;
					end else begin
						src_d = step_y;
					end
				end else begin
					if (at_last) begin
						fill_d  = fill_q - CW'(1);
						state_d = ile_pkg::S_DONE;
					end else begin
						src_d = step_y;
					end
				end
			end

			ile_pkg::S_FIN: begin
				// place the new word into the opened slot
				mem_we  = 1'b1;
				fill_d  = fill_q + CW'(1);
				state_d = ile_pkg::S_DONE;
			end

			ile_pkg::S_DONE: begin
				res_valid = 1'b1;
				if (res_take) begin
					state_d = ile_pkg::S_IDLE;
				end
			end

			default: begin
				state_d = ile_pkg::S_IDLE;
			end
		endcase
	end

	// Result word
	assign res.data_out = DW'(data_q);
	assign res.status   = status_q;
	assign res.count    = NW'(fill_q);
	assign res.is_empty = fill_q == '0;

endmodule

`default_nettype wire

// ----- src/indexed_list_engine_core.sv -----
// Indexed list engine: an ordered list of up to CAPACITY data words.
// Requests arrive on req (operation, position, value) and each one yields
// exactly one response word on rsp (data_out, status, count, is_empty).
// Both channels move a word when valid and ready are high at a clock edge.
// With rsp ready, the next request is taken at the same edge as the
// response to the previous one.
// The entry store has one write and one read port; insert and delete walk
// it one entry per cycle, so one request is worked on at a time and req is
// not ready until the result is handed to the output register.
// The output register lets the next request be accepted while a response
// waits; if rsp stalls, the following result holds inside the engine and
// req stays low until the output register frees.
// Reset empties the list (count zero), clears rsp valid and leaves req ready;
// stored words are not cleared and are never read before being written.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// ----------------------------------------------------------------------------
// indexed_list_engine_core
// Top level: sequencer, address stepper, entry store and response register.
// ----------------------------------------------------------------------------
module indexed_list_engine_core #(
	parameter int CAPACITY  = 64,
	parameter int WORD_BITS = 32
) (
	input  logic  clk,
	input  logic  arst_n,
	ile_req_if.sink   req,
	ile_rsp_if.source rsp
);

	localparam int IW = $clog2(CAPACITY);

	logic                 res_valid;
	logic                 res_take;
	ile_pkg::result_t     res;
	logic                 mem_we;
	logic [IW-1:0]        mem_waddr;
	logic [WORD_BITS-1:0] mem_wdata;
	logic [IW-1:0]        mem_raddr;
	logic [WORD_BITS-1:0] mem_rdata;
	logic                 out_valid_q;
	ile_pkg::result_t     out_q;

	// Sequencer
	ile_seq #(
		.CAPACITY  (CAPACITY),
		.WORD_BITS (WORD_BITS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.operation (req.operation),
		.position  (req.position),
		.value     (req.value),
		.res_valid (res_valid),
		.res       (res),
		.res_take  (res_take),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	// Entry store
	ile_mem #(
		.DEPTH (CAPACITY),
		.WIDTH (WORD_BITS)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Response register
	assign res_take = res_valid && (!out_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.data_out = out_q.data_out;
	assign rsp.status   = out_q.status;
	assign rsp.count    = out_q.count;
	assign rsp.is_empty = out_q.is_empty;

	// Checks
	`AM_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, req.valid && req.ready, !req.ready, "request accepted while engine still busy")
	`AM_ASSERT(a_err_zero_data, clk, arst_n, !(rsp.valid && rsp.status != ile_pkg::ST_OK) || rsp.data_out == '0, "error response carries nonzero data")
	`AM_ASSERT(a_empty_status, clk, arst_n, !(rsp.valid && rsp.status == ile_pkg::ST_EMPTY) || rsp.is_empty, "empty status on a non-empty list")
	`AM_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp.valid && !rsp.ready, rsp.valid && $stable(rsp.count), "stalled response changed")

endmodule

`default_nettype wire
